// File: sv/e2c_pkg.sv
// Package of the equirectangular to cube face coordinate core.
// Holds fixed-point constants, the arctangent table, codes and the stage types.
// Depends on nothing; every other file of the block refers to it by scoped names.
package e2c_pkg;

   // Fixed-point format and limits.
   localparam int FRAC_BITS     = 16;
   localparam int ONE           = 1 << FRAC_BITS;
   localparam int DW            = FRAC_BITS + 8;
   localparam int RW            = FRAC_BITS + 26;
   localparam int QW            = FRAC_BITS + 2;
   localparam int PW            = FRAC_BITS;
   localparam int NW            = FRAC_BITS + 5;
   localparam int MAX_FACE_SIZE = 4096;
   localparam int MAX_SRC_WIDTH = 16384;
   localparam int CORDIC_STEPS  = 16;
   localparam int TAB_LEN       = 24;

   // Arctangent of 2^-i in Q30.
   localparam logic [31:0] ATAN_Q30 [TAB_LEN] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   // Rounds a Q30 constant to nearest in the working format.
   function automatic logic signed [DW-1:0] from_q30(input logic [31:0] v);
      logic [32:0] t;
      t = {1'b0, v} + (33'd1 << (29 - FRAC_BITS));
      return DW'(t >> (30 - FRAC_BITS));
   endfunction

   localparam logic signed [DW-1:0] PI_Q  = from_q30(32'hC90FDAA2);
   localparam logic signed [DW-1:0] HPI_Q = from_q30(32'h6487ED51);
   localparam logic signed [DW-1:0] AK_Q  = from_q30(32'h2D413CCD);
   localparam logic signed [DW-1:0] KG_Q  = from_q30(32'h26DD3B6A);

   typedef enum logic [2:0] {
      FACE_FRONT = 3'd0,
      FACE_RIGHT = 3'd1,
      FACE_BACK  = 3'd2,
      FACE_LEFT  = 3'd3,
      FACE_UP    = 3'd4,
      FACE_DOWN  = 3'd5
   } face_type;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH   = 2'd0,
      CSR_SRC_HEIGHT  = 2'd1,
      CSR_FACE_SIZE   = 2'd2,
      CSR_FACE_SELECT = 2'd3
   } csr_type;

   // One CORDIC lane.
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] z;
   } cordic_lane_type;

   // One restoring divider lane.
   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QW-1:0] q;
   } div_lane_type;

   // What travels alongside the arithmetic of an item.
   typedef struct packed {
      logic                 vld;
      logic [11:0]          col;
      logic [11:0]          row;
      logic signed [DW-1:0] a;
      logic signed [DW-1:0] b;
      logic [3:0]           flag;
   } side_type;

endpackage

// File: sv/equirect_to_cube_face_coordinate_core.sv
// Top level of the equirectangular to cube face coordinate core.
// Depends on e2c_pkg, e2c_div_cell and e2c_cordic_cell.
//
//   Channel   Direction  Handshake             Carries
//   req_      in         req_valid/req_ready   dst_col, dst_row
//   rsp_      out        rsp_valid/rsp_ready   face, columns, rows, fractions
//   csr_      in         csr_we                register index and data
//
// One item is accepted per cycle while no result waits untaken; each item passes in turn
// through the plane divider, the three CORDIC chains and the angle divider.
// A low rsp_ready while a result waits stalls the whole pipeline, and req_ready with it.
// Reset clears the stage valids and loads the register defaults; there is no clearing pass.
module equirect_to_cube_face_coordinate_core #(
   parameter int CORDIC_STEPS = e2c_pkg::CORDIC_STEPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_dst_col,
   input  logic [11:0] req_dst_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_face_out,
   output logic [11:0] rsp_out_col,
   output logic [11:0] rsp_out_row,
   output logic [13:0] rsp_src_col,
   output logic [12:0] rsp_src_row,
   output logic [6:0]  rsp_frac_col,
   output logic [6:0]  rsp_frac_row,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int FB = e2c_pkg::FRAC_BITS;
   localparam int DW = e2c_pkg::DW;
   localparam int RW = e2c_pkg::RW;
   localparam int QW = e2c_pkg::QW;
   localparam int PW = e2c_pkg::PW;
   localparam int NW = e2c_pkg::NW;
   localparam logic signed [NW-1:0] ONE_N = NW'(e2c_pkg::ONE);

   // Configuration registers.
   logic [14:0] src_width_ff;
   logic [13:0] src_height_ff;
   logic [12:0] face_size_ff;
   logic [2:0]  face_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= 15'd4096;
         src_height_ff  <= 14'd2048;
         face_size_ff   <= 13'd1024;
         face_select_ff <= e2c_pkg::FACE_FRONT;
      end else if (csr_we) begin
         unique case (csr_index)
            e2c_pkg::CSR_SRC_WIDTH:   src_width_ff   <= csr_wdata;
            e2c_pkg::CSR_SRC_HEIGHT:  src_height_ff  <= csr_wdata[13:0];
            e2c_pkg::CSR_FACE_SIZE:   face_size_ff   <= csr_wdata[12:0];
            e2c_pkg::CSR_FACE_SELECT: face_select_ff <= csr_wdata[2:0];
         endcase
      end
   end

   // Effective settings; users change them only with an empty pipeline; not enforced.
   logic [12:0]       s_eff;
   logic [14:0]       w_eff, wm1;
   logic [13:0]       hm1;
   e2c_pkg::face_type face_eff;
   logic              front;

   always_comb begin
      if (face_size_ff == '0) s_eff = 13'd1;
      else if (32'(face_size_ff) > e2c_pkg::MAX_FACE_SIZE) s_eff = 13'(e2c_pkg::MAX_FACE_SIZE);
      else s_eff = face_size_ff;
      if (32'(src_width_ff) > e2c_pkg::MAX_SRC_WIDTH) w_eff = 15'(e2c_pkg::MAX_SRC_WIDTH);
      else w_eff = src_width_ff;
      wm1 = (w_eff != '0) ? w_eff - 15'd1 : '0;
      hm1 = (src_height_ff != '0) ? src_height_ff - 14'd1 : '0;
      face_eff = (face_select_ff > e2c_pkg::FACE_DOWN) ? e2c_pkg::FACE_FRONT
                                                       : e2c_pkg::face_type'(face_select_ff);
      front = (face_eff != e2c_pkg::FACE_UP) && (face_eff != e2c_pkg::FACE_DOWN);
   end

   // The whole pipeline moves unless a result waits and is not taken.
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Plane numerators: |2k - s| scaled, with sign and saturation flags.
   e2c_pkg::div_lane_type [1:0] p0_lane_ff, p0_lane_in;
   e2c_pkg::side_type           p0_side_ff, p0_side_in;

   always_comb begin
      logic signed [14:0] d;
      logic [13:0]        mag;
      logic [11:0]        k;
      p0_side_in      = '0;
      p0_side_in.vld  = req_valid;
      p0_side_in.col  = req_dst_col;
      p0_side_in.row  = req_dst_row;
      for (int i = 0; i < 2; i++) begin
         k   = (i == 0) ? req_dst_row : req_dst_col;
         d   = signed'({2'b00, k, 1'b0}) - signed'({2'b00, s_eff});
         mag = d[14] ? 14'(-d) : 14'(d);
         p0_lane_in[i].rem = RW'(mag) << FB;
         p0_lane_in[i].q   = '0;
         p0_side_in.flag[3-2*i] = ({1'b0, mag} >= {2'b00, s_eff});
         p0_side_in.flag[2-2*i] = d[14];
      end
   end

   always_ff @(posedge clock) begin
      if (en) p0_lane_ff <= p0_lane_in;
      if (reset) p0_side_ff.vld <= 1'b0;
      else if (en) p0_side_ff <= p0_side_in;
   end

   // Plane divider chain, one quotient bit per cell.
   e2c_pkg::div_lane_type [1:0] pl_lane [PW+1];
   e2c_pkg::side_type           pl_side [PW+1];
   logic [1:0][RW-1:0]          s_div;

   assign s_div      = {RW'(s_eff), RW'(s_eff)};
   assign pl_lane[0] = p0_lane_ff;
   assign pl_side[0] = p0_side_ff;

   for (genvar j = 0; j < PW; j++) begin : g_plane
      e2c_div_cell #(.BIT(PW - 1 - j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .divisor (s_div),
         .up_lane (pl_lane[j]),
         .up_side (pl_side[j]),
         .dn_lane (pl_lane[j+1]),
         .dn_side (pl_side[j+1])
      );
   end

   // Signed plane coordinate times sin(pi/4).
   logic signed [DW-1:0] nx_ff, ny_ff, nx_in, ny_in;
   e2c_pkg::side_type    n_side_ff;

   always_comb begin
      logic signed [FB+1:0]    t;
      logic signed [FB+DW+1:0] prod;
      nx_in = '0;
      ny_in = '0;
      for (int i = 0; i < 2; i++) begin
         t = pl_side[PW].flag[3-2*i] ? (FB+2)'(e2c_pkg::ONE) : (FB+2)'(pl_lane[PW][i].q);
         if (pl_side[PW].flag[2-2*i]) t = -t;
         prod = t * e2c_pkg::AK_Q;
         if (i == 0) nx_in = DW'(prod >>> FB);
         else        ny_in = DW'(prod >>> FB);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff <= nx_in;
         ny_ff <= ny_in;
      end
      if (reset) n_side_ff.vld <= 1'b0;
      else if (en) n_side_ff <= pl_side[PW];
   end

   // First CORDIC chain: front angle, or up/down magnitude in lane 0 and azimuth in lane 1.
   e2c_pkg::cordic_lane_type [1:0] a_prep;
   e2c_pkg::side_type              a_prep_side;
   e2c_pkg::cordic_lane_type [1:0] a_lane [CORDIC_STEPS+1];
   e2c_pkg::side_type              a_side [CORDIC_STEPS+1];

   always_comb begin
      a_prep_side   = n_side_ff;
      a_prep_side.a = ny_ff;
      a_prep[0].z   = '0;
      if (front) begin
         a_prep[0].x = e2c_pkg::AK_Q;
         a_prep[0].y = nx_ff;
      end else begin
         a_prep[0].x = ny_ff[DW-1] ? -ny_ff : ny_ff;
         a_prep[0].y = nx_ff[DW-1] ? -nx_ff : nx_ff;
      end
      // A negative x is turned through pi first.
      if (nx_ff[DW-1]) begin
         a_prep[1].x = -nx_ff;
         a_prep[1].y = ny_ff;
         a_prep[1].z = (ny_ff <= 0) ? e2c_pkg::PI_Q : -e2c_pkg::PI_Q;
      end else begin
         a_prep[1].x = nx_ff;
         a_prep[1].y = -ny_ff;
         a_prep[1].z = '0;
      end
   end

   assign a_lane[0] = a_prep;
   assign a_side[0] = a_prep_side;

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_chain_a
      e2c_cordic_cell #(.STEP(j), .VECTOR(1'b1), .LANES(2)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_lane (a_lane[j]),
         .up_side (a_side[j]),
         .dn_lane (a_lane[j+1]),
         .dn_side (a_side[j+1])
      );
   end

   // Second CORDIC chain: cosine of the front angle.
   e2c_pkg::cordic_lane_type [0:0] b_prep;
   e2c_pkg::side_type              b_prep_side;
   e2c_pkg::cordic_lane_type [0:0] b_lane [CORDIC_STEPS+1];
   e2c_pkg::side_type              b_side [CORDIC_STEPS+1];

   always_comb begin
      b_prep_side = a_side[CORDIC_STEPS];
      b_prep[0].x = e2c_pkg::KG_Q;
      b_prep[0].y = '0;
      if (front) begin
         b_prep[0].z   = a_lane[CORDIC_STEPS][0].z;
         b_prep_side.b = a_lane[CORDIC_STEPS][0].z;
      end else begin
         b_prep[0].z   = '0;
         b_prep_side.a = a_lane[CORDIC_STEPS][0].x;
         b_prep_side.b = a_lane[CORDIC_STEPS][1].z + e2c_pkg::HPI_Q;
      end
   end

   assign b_lane[0] = b_prep;
   assign b_side[0] = b_prep_side;

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_chain_b
      e2c_cordic_cell #(.STEP(j), .VECTOR(1'b0), .LANES(1)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_lane (b_lane[j]),
         .up_side (b_side[j]),
         .dn_lane (b_lane[j+1]),
         .dn_side (b_side[j+1])
      );
   end

   // Front: ny times the cosine. Up and down: CORDIC gain correction of the magnitude.
   logic signed [DW-1:0] ym_ff, ym_in;
   e2c_pkg::side_type    m_side_ff;

   always_comb begin
      logic signed [DW-1:0]   factor;
      logic signed [2*DW-1:0] prod;
      factor = front ? b_lane[CORDIC_STEPS][0].x : e2c_pkg::KG_Q;
      prod   = b_side[CORDIC_STEPS].a * factor;
      ym_in  = DW'(prod >>> FB);
   end

   always_ff @(posedge clock) begin
      if (en) ym_ff <= ym_in;
      if (reset) m_side_ff.vld <= 1'b0;
      else if (en) m_side_ff <= b_side[CORDIC_STEPS];
   end

   // Third CORDIC chain: elevation angle.
   e2c_pkg::cordic_lane_type [0:0] c_prep;
   e2c_pkg::cordic_lane_type [0:0] c_lane [CORDIC_STEPS+1];
   e2c_pkg::side_type              c_side [CORDIC_STEPS+1];

   assign c_prep[0].x = e2c_pkg::AK_Q;
   assign c_prep[0].y = ym_ff;
   assign c_prep[0].z = '0;
   assign c_lane[0]   = c_prep;
   assign c_side[0]   = m_side_ff;

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_chain_c
      e2c_cordic_cell #(.STEP(j), .VECTOR(1'b1), .LANES(1)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_lane (c_lane[j]),
         .up_side (c_side[j]),
         .dn_lane (c_lane[j+1]),
         .dn_side (c_side[j+1])
      );
   end

   // Angle normalisation: |u|/pi in lane 0 and |v|/(pi/2) in lane 1.
   e2c_pkg::div_lane_type [1:0] d_prep;
   e2c_pkg::side_type           d_prep_side;
   e2c_pkg::div_lane_type [1:0] d_lane [QW+1];
   e2c_pkg::side_type           d_side [QW+1];
   logic [1:0][RW-1:0]          ang_div;

   always_comb begin
      logic signed [DW-1:0] u, v;
      u = c_side[CORDIC_STEPS].b;
      v = front ? c_lane[CORDIC_STEPS][0].z : c_lane[CORDIC_STEPS][0].z - e2c_pkg::HPI_Q;
      d_prep_side      = c_side[CORDIC_STEPS];
      d_prep_side.flag = {2'b00, u[DW-1], v[DW-1]};
      d_prep[0].rem    = RW'(u[DW-1] ? -u : u) << FB;
      d_prep[1].rem    = RW'(v[DW-1] ? -v : v) << FB;
      d_prep[0].q      = '0;
      d_prep[1].q      = '0;
   end

   assign ang_div   = {RW'(e2c_pkg::HPI_Q), RW'(e2c_pkg::PI_Q)};
   assign d_lane[0] = d_prep;
   assign d_side[0] = d_prep_side;

   for (genvar j = 0; j < QW; j++) begin : g_angle
      e2c_div_cell #(.BIT(QW - 1 - j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .divisor (ang_div),
         .up_lane (d_lane[j]),
         .up_side (d_side[j]),
         .dn_lane (d_lane[j+1]),
         .dn_side (d_side[j+1])
      );
   end

   // Signs, wrap-around, clamping and the move to [0, 1].
   logic [FB:0]       pc_ff, pr_ff, pc_in, pr_in;
   e2c_pkg::side_type e1_side_ff;

   always_comb begin
      logic signed [NW-1:0] un, vn, tc, tr;
      un = signed'(NW'(d_lane[QW][0].q));
      vn = signed'(NW'(d_lane[QW][1].q));
      if (d_side[QW].flag[1]) un = -un;
      if (d_side[QW].flag[0]) vn = -vn;
      if (vn < -ONE_N) begin
         vn = vn + 2 * ONE_N;
         un = un + ONE_N;
      end else if (vn > ONE_N) begin
         vn = vn - 2 * ONE_N;
         un = un + ONE_N;
      end
      if (un < -ONE_N) un = un + 2 * ONE_N;
      else if (un > ONE_N) un = un - 2 * ONE_N;
      if (un < -ONE_N) un = -ONE_N;
      if (un > ONE_N)  un = ONE_N;
      if (vn < -ONE_N) vn = -ONE_N;
      if (vn > ONE_N)  vn = ONE_N;
      tc    = un + ONE_N;
      tr    = vn + ONE_N;
      pc_in = tc[FB+1:1];
      pr_in = tr[FB+1:1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff <= pc_in;
         pr_ff <= pr_in;
      end
      if (reset) e1_side_ff.vld <= 1'b0;
      else if (en) e1_side_ff <= d_side[QW];
   end

   // Texture positions.
   logic [FB+15:0]    posc_ff, posr_ff;
   e2c_pkg::side_type e2_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         posc_ff <= (FB+16)'(pc_ff) * (FB+16)'(wm1);
         posr_ff <= (FB+16)'(pr_ff) * (FB+16)'(hm1);
      end
      if (reset) e2_side_ff.vld <= 1'b0;
      else if (en) e2_side_ff <= e1_side_ff;
   end

   // Integer parts, fractions in hundredths and the per-face column shift.
   logic [15:0]       sc_ff, sc_in, sr_ff;
   logic [6:0]        fc_ff, fr_ff, fc_in, fr_in;
   e2c_pkg::side_type e3_side_ff;

   always_comb begin
      logic [FB+6:0] fmc, fmr;
      logic [15:0]   w16, ipc;
      w16   = {1'b0, w_eff};
      ipc   = posc_ff[FB+15:FB];
      fmc   = (FB+7)'(posc_ff[FB-1:0]) * (FB+7)'(100);
      fmr   = (FB+7)'(posr_ff[FB-1:0]) * (FB+7)'(100);
      fc_in = fmc[FB+6:FB];
      fr_in = fmr[FB+6:FB];
      sc_in = ipc;
      if (w_eff != '0) begin
         unique case (face_eff)
            e2c_pkg::FACE_RIGHT: begin
               sc_in = ipc + (w16 >> 2);
               if (sc_in >= w16) sc_in = sc_in - w16;
            end
            e2c_pkg::FACE_BACK: begin
               sc_in = ipc + (w16 >> 1);
               if (sc_in >= w16) sc_in = sc_in - w16;
            end
            e2c_pkg::FACE_LEFT: begin
               sc_in = (ipc >= (w16 >> 2)) ? ipc - (w16 >> 2) : ipc + w16 - (w16 >> 2);
            end
            default: sc_in = ipc;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff <= sc_in;
         sr_ff <= posr_ff[FB+15:FB];
         fc_ff <= fc_in;
         fr_ff <= fr_in;
      end
      if (reset) e3_side_ff.vld <= 1'b0;
      else if (en) e3_side_ff <= e2_side_ff;
   end

   // Down-face mirroring and range clamps into the output register.
   logic [2:0]  face_out_ff;
   logic [11:0] out_col_ff, out_row_ff, out_col_in;
   logic [13:0] src_col_ff, src_col_in;
   logic [12:0] src_row_ff, src_row_in;
   logic [6:0]  frac_col_ff, frac_row_ff, frac_row_in;

   always_comb begin
      logic [15:0] h16, sr;
      logic [12:0] oc;
      h16         = {2'b00, src_height_ff};
      sr          = sr_ff;
      frac_row_in = fr_ff;
      out_col_in  = e3_side_ff.col;
      oc          = s_eff - 13'd1 - {1'b0, e3_side_ff.col};
      if (face_eff == e2c_pkg::FACE_DOWN) begin
         sr          = (h16 >= sr_ff) ? h16 - sr_ff : '0;
         if (sr > {2'b00, hm1}) sr = {2'b00, hm1};
         frac_row_in = 7'd100 - fr_ff;
         out_col_in  = oc[11:0];
      end
      src_col_in = (sc_ff > 16'd16383) ? 14'h3FFF : sc_ff[13:0];
      src_row_in = (sr > 16'd8191) ? 13'h1FFF : sr[12:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         face_out_ff  <= face_eff;
         out_col_ff   <= out_col_in;
         out_row_ff   <= e3_side_ff.row;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         frac_col_ff  <= fc_ff;
         frac_row_ff  <= frac_row_in;
      end
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= e3_side_ff.vld;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_face_out = face_out_ff;
   assign rsp_out_col  = out_col_ff;
   assign rsp_out_row  = out_row_ff;
   assign rsp_src_col  = src_col_ff;
   assign rsp_src_row  = src_row_ff;
   assign rsp_frac_col = frac_col_ff;
   assign rsp_frac_row = frac_row_ff;

endmodule

// File: sv/e2c_div_cell.sv
// One cell of a two-lane restoring divider chain: settles one quotient bit per lane.
// Depends on e2c_pkg.
module e2c_div_cell #(
   parameter int BIT = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic [1:0][e2c_pkg::RW-1:0]           divisor,
   input  e2c_pkg::div_lane_type [1:0]           up_lane,
   input  e2c_pkg::side_type                     up_side,
   output e2c_pkg::div_lane_type [1:0]           dn_lane,
   output e2c_pkg::side_type                     dn_side
);

   e2c_pkg::div_lane_type [1:0] lane_ff, lane_in;
   e2c_pkg::side_type           side_ff;

   // Subtract the shifted divisor where it fits and set the quotient bit.
   always_comb begin
      logic [e2c_pkg::RW-1:0] trial;
      for (int i = 0; i < 2; i++) begin
         trial      = divisor[i] << BIT;
         lane_in[i] = up_lane[i];
         if (up_lane[i].rem >= trial) begin
            lane_in[i].rem = up_lane[i].rem - trial;
            lane_in[i].q   = up_lane[i].q | (e2c_pkg::QW'(1) << BIT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) lane_ff <= lane_in;
      if (reset) side_ff.vld <= 1'b0;
      else if (en) side_ff <= up_side;
   end

   assign dn_lane = lane_ff;
   assign dn_side = side_ff;

endmodule

// File: sv/e2c_cordic_cell.sv
// One CORDIC micro-rotation cell, vectoring or rotating, over one or more lanes.
// Depends on e2c_pkg.
module e2c_cordic_cell #(
   parameter int STEP   = 0,
   parameter bit VECTOR = 1'b1,
   parameter int LANES  = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  e2c_pkg::cordic_lane_type [LANES-1:0]   up_lane,
   input  e2c_pkg::side_type                      up_side,
   output e2c_pkg::cordic_lane_type [LANES-1:0]   dn_lane,
   output e2c_pkg::side_type                      dn_side
);

   localparam logic signed [e2c_pkg::DW-1:0] ANG = e2c_pkg::from_q30(e2c_pkg::ATAN_Q30[STEP]);

   e2c_pkg::cordic_lane_type [LANES-1:0] lane_ff, lane_in;
   e2c_pkg::side_type                    side_ff;

   // Vectoring drives y towards zero; rotation drives z towards zero.
   always_comb begin
      logic signed [e2c_pkg::DW-1:0] xs, ys;
      logic                          pos;
      for (int i = 0; i < LANES; i++) begin
         xs  = up_lane[i].x >>> STEP;
         ys  = up_lane[i].y >>> STEP;
         pos = VECTOR ? !up_lane[i].y[e2c_pkg::DW-1] : !up_lane[i].z[e2c_pkg::DW-1];
         if (pos == VECTOR) begin
            lane_in[i].x = up_lane[i].x + ys;
            lane_in[i].y = up_lane[i].y - xs;
         end else begin
            lane_in[i].x = up_lane[i].x - ys;
            lane_in[i].y = up_lane[i].y + xs;
         end
         lane_in[i].z = pos ? up_lane[i].z + (VECTOR ? ANG : -ANG)
                            : up_lane[i].z - (VECTOR ? ANG : -ANG);
      end
   end

   always_ff @(posedge clock) begin
      if (en) lane_ff <= lane_in;
      if (reset) side_ff.vld <= 1'b0;
      else if (en) side_ff <= up_side;
   end

   assign dn_lane = lane_ff;
   assign dn_side = side_ff;

endmodule

// File: sv/e2c_checker.sv
// Port-level checks of the cube face coordinate core, and the bind that attaches them.
// Depends on e2c_pkg and equirect_to_cube_face_coordinate_core.
module e2c_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_face_out,
   input logic [6:0]  rsp_frac_col,
   input logic [6:0]  rsp_frac_row
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // With no result waiting the block always takes an item.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with an empty output");

   // A waiting result stalls the input side too.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while the pipeline is stalled");

   // Result fields stay within their ranges.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frac_col <= 7'd99) && (rsp_frac_row <= 7'd100)
                    && (rsp_face_out <= e2c_pkg::FACE_DOWN))
      else $error("result field out of range");

   // Reset leaves no result offered.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind equirect_to_cube_face_coordinate_core e2c_checker u_e2c_checker (.*);
